@@ rtl/lsps_pkg.sv @@
// Shared types, constants and register codes for the line sensor PD steering block.
// Used by the channel interfaces, the steering datapath and the top level.
package lsps_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int NUM_SENSORS   = 7;
    localparam int THRESH_BITS   = 12;
    localparam int GAIN_BITS     = 10;
    localparam int DUTY_BITS     = 12;
    localparam int ERR_BITS      = 4;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 12;

    localparam logic [THRESH_BITS-1:0] RST_THRESHOLD  = 12'd4050;
    localparam logic [GAIN_BITS-1:0]   RST_GAIN_PROP  = 10'd200;
    localparam logic [GAIN_BITS-1:0]   RST_GAIN_DERIV = 10'd120;
    localparam logic [DUTY_BITS-1:0]   RST_BASE_DUTY  = 12'd900;
    localparam logic [DUTY_BITS-1:0]   RST_DUTY_LIMIT = 12'd999;

    localparam logic signed [ERR_BITS-1:0] WEIGHT_TAB [NUM_SENSORS] = '{
        -4'sd5, -4'sd3, -4'sd2, 4'sd0, 4'sd2, 4'sd3, 4'sd5
    };

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_THRESHOLD  = 3'd0,
        REG_GAIN_PROP  = 3'd1,
        REG_GAIN_DERIV = 3'd2,
        REG_BASE_DUTY  = 3'd3,
        REG_DUTY_LIMIT = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [THRESH_BITS-1:0] detect_threshold;
        logic [GAIN_BITS-1:0]   gain_prop;
        logic [GAIN_BITS-1:0]   gain_deriv;
        logic [DUTY_BITS-1:0]   base_duty;
        logic [DUTY_BITS-1:0]   duty_limit;
    } t_cfg;

    typedef struct packed {
        logic [DUTY_BITS-1:0]       duty_left;
        logic [DUTY_BITS-1:0]       duty_right;
        logic [NUM_SENSORS-1:0]     line_mask;
        logic signed [ERR_BITS-1:0] position_error;
    } t_steer_res;

endpackage

@@ rtl/lsps_if.sv @@
// Valid/ready channel interfaces: sensor frames in, steering results out, register writes.
// Depends on lsps_pkg for field widths.
interface lsps_frame_if #(
    parameter int SAMPLE_BITS = lsps_pkg::SAMPLE_BITS
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_0;
    logic [SAMPLE_BITS-1:0] sample_1;
    logic [SAMPLE_BITS-1:0] sample_2;
    logic [SAMPLE_BITS-1:0] sample_3;
    logic [SAMPLE_BITS-1:0] sample_4;
    logic [SAMPLE_BITS-1:0] sample_5;
    logic [SAMPLE_BITS-1:0] sample_6;

    modport source (output valid, sample_0, sample_1, sample_2, sample_3, sample_4,
                    sample_5, sample_6, input ready);
    modport sink   (input valid, sample_0, sample_1, sample_2, sample_3, sample_4,
                    sample_5, sample_6, output ready);
endinterface

interface lsps_result_if;
    logic                                 valid;
    logic                                 ready;
    logic [lsps_pkg::DUTY_BITS-1:0]       duty_left;
    logic [lsps_pkg::DUTY_BITS-1:0]       duty_right;
    logic [lsps_pkg::NUM_SENSORS-1:0]     line_mask;
    logic signed [lsps_pkg::ERR_BITS-1:0] position_error;

    modport source (output valid, duty_left, duty_right, line_mask, position_error,
                    input ready);
    modport sink   (input valid, duty_left, duty_right, line_mask, position_error,
                    output ready);
endinterface

interface lsps_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [lsps_pkg::CFG_IDX_BITS-1:0]  index;
    logic [lsps_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/line_sensor_pd_steering.sv @@
// Top level of the line sensor PD steering block: register file, input and result registers.
// Depends on lsps_pkg, the channel interfaces in lsps_if and lsps_steer_calc.
//
//   Channel    Dir  Handshake      Beat carries
//   i_frame    in   valid/ready    sample_0 .. sample_6
//   o_result   out  valid/ready    duty_left, duty_right, line_mask, position_error
//   i_cfg      in   valid/ready    index, data (ready is always high)
//
// One frame is taken per cycle while the result side is not stalled; a frame is captured in
// the input register and its result in the result register. The held error feeds back
// from the steering datapath into itself within the single input-to-result stage.
// Reset is synchronous, clears both valid flags and the held error and loads the register defaults.
// A stalled result holds in the result register while one more frame waits at the input.
module line_sensor_pd_steering #(
    parameter int SAMPLE_BITS = lsps_pkg::SAMPLE_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lsps_frame_if.sink    i_frame,
    lsps_result_if.source o_result,
    lsps_cfg_if.sink      i_cfg
);

    logic                                              r_s1_vld;
    logic [lsps_pkg::NUM_SENSORS-1:0][SAMPLE_BITS-1:0] r_s1_samples;
    logic                                              r_out_vld;
    lsps_pkg::t_steer_res                              r_out;
    logic signed [lsps_pkg::ERR_BITS-1:0]              r_last_error;
    lsps_pkg::t_cfg                                    r_cfg;
    lsps_pkg::t_cfg                                    n_cfg;
    lsps_pkg::t_steer_res                              n_out;
    logic                                              out_free;
    logic                                              s1_adv;
    logic                                              in_acc;

    assign out_free      = !r_out_vld || o_result.ready;
    assign s1_adv        = r_s1_vld && out_free;
    assign i_frame.ready = !r_s1_vld || out_free;
    assign in_acc        = i_frame.valid && i_frame.ready;
    assign i_cfg.ready   = 1'b1;

    lsps_steer_calc #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_calc (
        .i_samples   (r_s1_samples),
        .i_cfg       (r_cfg),
        .i_last_error(r_last_error),
        .o_res       (n_out)
    );

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (lsps_pkg::t_reg_idx'(i_cfg.index))
                lsps_pkg::REG_THRESHOLD:  n_cfg.detect_threshold = i_cfg.data;
                lsps_pkg::REG_GAIN_PROP:
                    n_cfg.gain_prop = i_cfg.data[lsps_pkg::GAIN_BITS-1:0];
                lsps_pkg::REG_GAIN_DERIV:
                    n_cfg.gain_deriv = i_cfg.data[lsps_pkg::GAIN_BITS-1:0];
                lsps_pkg::REG_BASE_DUTY:  n_cfg.base_duty  = i_cfg.data;
                lsps_pkg::REG_DUTY_LIMIT: n_cfg.duty_limit = i_cfg.data;
                default:                  n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.detect_threshold <= lsps_pkg::RST_THRESHOLD;
            r_cfg.gain_prop        <= lsps_pkg::RST_GAIN_PROP;
            r_cfg.gain_deriv       <= lsps_pkg::RST_GAIN_DERIV;
            r_cfg.base_duty        <= lsps_pkg::RST_BASE_DUTY;
            r_cfg.duty_limit       <= lsps_pkg::RST_DUTY_LIMIT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_last_error <= '0;
        end else begin
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld    <= 1'b1;
                r_last_error <= n_out.position_error;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_samples[0] <= i_frame.sample_0;
            r_s1_samples[1] <= i_frame.sample_1;
            r_s1_samples[2] <= i_frame.sample_2;
            r_s1_samples[3] <= i_frame.sample_3;
            r_s1_samples[4] <= i_frame.sample_4;
            r_s1_samples[5] <= i_frame.sample_5;
            r_s1_samples[6] <= i_frame.sample_6;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid          = r_out_vld;
    assign o_result.duty_left      = r_out.duty_left;
    assign o_result.duty_right     = r_out.duty_right;
    assign o_result.line_mask      = r_out.line_mask;
    assign o_result.position_error = r_out.position_error;

endmodule

@@ rtl/lsps_steer_calc.sv @@
// Steering datapath: threshold mask, first-hit error pick, PD correction and duty clamp.
// Purely combinational; depends on lsps_pkg.
module lsps_steer_calc #(
    parameter int SAMPLE_BITS = lsps_pkg::SAMPLE_BITS
) (
    input  logic [lsps_pkg::NUM_SENSORS-1:0][SAMPLE_BITS-1:0] i_samples,
    input  lsps_pkg::t_cfg                                    i_cfg,
    input  logic signed [lsps_pkg::ERR_BITS-1:0]              i_last_error,
    output lsps_pkg::t_steer_res                              o_res
);

    localparam int CMP_W  = (SAMPLE_BITS > lsps_pkg::THRESH_BITS) ?
                            SAMPLE_BITS : lsps_pkg::THRESH_BITS;
    localparam int CORR_W = 16;
    localparam int SUM_W  = 18;

    logic [lsps_pkg::NUM_SENSORS-1:0]     mask;
    logic signed [lsps_pkg::ERR_BITS-1:0] err;
    logic signed [CORR_W-1:0]             err_w;
    logic signed [CORR_W-1:0]             diff_w;
    logic signed [CORR_W-1:0]             gp_w;
    logic signed [CORR_W-1:0]             gd_w;
    logic signed [CORR_W-1:0]             corr;
    logic signed [SUM_W-1:0]              base_w;
    logic signed [SUM_W-1:0]              corr_x;
    logic signed [SUM_W-1:0]              left_raw;
    logic signed [SUM_W-1:0]              right_raw;
    logic                                 err_pos;

    function automatic logic [lsps_pkg::DUTY_BITS-1:0] clamp_duty(
        input logic signed [SUM_W-1:0]      v,
        input logic [lsps_pkg::DUTY_BITS-1:0] lim
    );
        logic signed [SUM_W-1:0] lim_w;
        lim_w = SUM_W'(lim);
        if (v[SUM_W-1]) begin
            clamp_duty = '0;
        end else if (v > lim_w) begin
            clamp_duty = lim;
        end else begin
            clamp_duty = v[lsps_pkg::DUTY_BITS-1:0];
        end
    endfunction

    always_comb begin
        for (int i = 0; i < lsps_pkg::NUM_SENSORS; i++) begin
            mask[i] = CMP_W'(i_samples[i]) > CMP_W'(i_cfg.detect_threshold);
        end
    end

    // Scanning downward lets the lowest-numbered detecting sensor win.
    always_comb begin
        err = i_last_error;
        for (int i = lsps_pkg::NUM_SENSORS - 1; i >= 0; i--) begin
            if (mask[i]) begin
                err = lsps_pkg::WEIGHT_TAB[i];
            end
        end
    end

    always_comb begin
        err_w     = CORR_W'(err);
        diff_w    = err_w - CORR_W'(i_last_error);
        gp_w      = signed'(CORR_W'(i_cfg.gain_prop));
        gd_w      = signed'(CORR_W'(i_cfg.gain_deriv));
        corr      = gp_w * err_w + gd_w * diff_w;
        base_w    = signed'(SUM_W'(i_cfg.base_duty));
        corr_x    = SUM_W'(corr);
        err_pos   = !err[lsps_pkg::ERR_BITS-1] && (err != '0);
        left_raw  = err_pos ? (base_w - corr_x) : base_w;
        right_raw = err_pos ? base_w : (base_w + corr_x);
    end

    assign o_res.duty_left      = clamp_duty(left_raw, i_cfg.duty_limit);
    assign o_res.duty_right     = clamp_duty(right_raw, i_cfg.duty_limit);
    assign o_res.line_mask      = mask;
    assign o_res.position_error = err;

endmodule

@@ rtl/lsps_checker.sv @@
// Port-level assertions for line_sensor_pd_steering, attached to it by a bind statement.
// Depends on lsps_pkg for field widths.
module lsps_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 i_in_ready,
    input logic                                 i_out_valid,
    input logic                                 i_out_ready,
    input logic [lsps_pkg::DUTY_BITS-1:0]       i_duty_left,
    input logic [lsps_pkg::DUTY_BITS-1:0]       i_duty_right,
    input logic [lsps_pkg::NUM_SENSORS-1:0]     i_line_mask,
    input logic signed [lsps_pkg::ERR_BITS-1:0] i_position_error
);

    logic [1:0]                           r_inflight;
    logic signed [lsps_pkg::ERR_BITS-1:0] r_prev_err;
    logic                                 in_beat;
    logic                                 out_beat;

    assign in_beat  = i_in_valid && i_in_ready;
    assign out_beat = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
            r_prev_err <= '0;
        end else begin
            r_inflight <= r_inflight + 2'(in_beat) - 2'(out_beat);
            if (out_beat) begin
                r_prev_err <= i_position_error;
            end
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_duty_left)
        && $stable(i_duty_right) && $stable(i_line_mask) && $stable(i_position_error))
        else $error("Stalled result beat changed.");

    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 2'd2)
        else $error("More than two frames held inside the block.");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_inflight != 2'd0)
        else $error("Result offered without an accepted frame.");

    a_held_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_line_mask == '0 |-> i_position_error == r_prev_err)
        else $error("Error not held when no sensor sees the line.");

endmodule

bind line_sensor_pd_steering lsps_checker u_lsps_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_frame.valid),
    .i_in_ready      (i_frame.ready),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_duty_left     (o_result.duty_left),
    .i_duty_right    (o_result.duty_right),
    .i_line_mask     (o_result.line_mask),
    .i_position_error(o_result.position_error)
);

@@ dv/line_sensor_pd_steering_checker.sv @@
// Scoreboard for the line sensor PD steering block: watches the frame, result and register
// channels, predicts each result beat and compares it with what the block returns.
// Depends on lsps_pkg and the channel interfaces in lsps_if.
module line_sensor_pd_steering_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    lsps_frame_if  i_frame,
    lsps_result_if i_result,
    lsps_cfg_if    i_cfg,
    output int     o_fail_count,
    output int     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [lsps_pkg::NUM_SENSORS-1:0][lsps_pkg::SAMPLE_BITS-1:0] t_frame;

    localparam int LANE_WEIGHT [lsps_pkg::NUM_SENSORS] = '{-5, -3, -2, 0, 2, 3, 5};

    lsps_pkg::t_cfg       steer_cfg;
    int                   held_error;
    lsps_pkg::t_steer_res pending_steer [$];

    function automatic logic [lsps_pkg::DUTY_BITS-1:0] duty_sat(input int v, input int lim);
        if (v < 0) return '0;
        if (v > lim) return lim[lsps_pkg::DUTY_BITS-1:0];
        return v[lsps_pkg::DUTY_BITS-1:0];
    endfunction

    function automatic lsps_pkg::t_steer_res predict_steering(input t_frame f);
        lsps_pkg::t_steer_res             res;
        logic [lsps_pkg::NUM_SENSORS-1:0] seen;
        bit                               found;
        int                               err, corr, gp, gd, base, lim, left, right;
        seen  = '0;
        found = 1'b0;
        err   = held_error;
        for (int k = 0; k < lsps_pkg::NUM_SENSORS; k++) begin
            if (f[k] > steer_cfg.detect_threshold) begin
                seen[k] = 1'b1;
                if (!found) begin
                    err   = LANE_WEIGHT[k];
                    found = 1'b1;
                end
            end
        end
        gp    = steer_cfg.gain_prop;
        gd    = steer_cfg.gain_deriv;
        base  = steer_cfg.base_duty;
        lim   = steer_cfg.duty_limit;
        corr  = gp * err + gd * (err - held_error);
        left  = (err > 0) ? base - corr : base;
        right = (err > 0) ? base : base + corr;
        res.duty_left      = duty_sat(left, lim);
        res.duty_right     = duty_sat(right, lim);
        res.line_mask      = seen;
        res.position_error = err[lsps_pkg::ERR_BITS-1:0];
        held_error = err;
        return res;
    endfunction

    always @(posedge i_clk) begin
        lsps_pkg::t_steer_res want, got;
        t_frame               f;
        if (!i_rst_n) begin
            steer_cfg.detect_threshold = lsps_pkg::RST_THRESHOLD;
            steer_cfg.gain_prop        = lsps_pkg::RST_GAIN_PROP;
            steer_cfg.gain_deriv       = lsps_pkg::RST_GAIN_DERIV;
            steer_cfg.base_duty        = lsps_pkg::RST_BASE_DUTY;
            steer_cfg.duty_limit       = lsps_pkg::RST_DUTY_LIMIT;
            held_error = 0;
            pending_steer.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    lsps_pkg::REG_THRESHOLD:
                        steer_cfg.detect_threshold = i_cfg.data[lsps_pkg::THRESH_BITS-1:0];
                    lsps_pkg::REG_GAIN_PROP:
                        steer_cfg.gain_prop = i_cfg.data[lsps_pkg::GAIN_BITS-1:0];
                    lsps_pkg::REG_GAIN_DERIV:
                        steer_cfg.gain_deriv = i_cfg.data[lsps_pkg::GAIN_BITS-1:0];
                    lsps_pkg::REG_BASE_DUTY:
                        steer_cfg.base_duty = i_cfg.data[lsps_pkg::DUTY_BITS-1:0];
                    lsps_pkg::REG_DUTY_LIMIT:
                        steer_cfg.duty_limit = i_cfg.data[lsps_pkg::DUTY_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_result.valid && i_result.ready) begin
                got.duty_left      = i_result.duty_left;
                got.duty_right     = i_result.duty_right;
                got.line_mask      = i_result.line_mask;
                got.position_error = i_result.position_error;
                if (pending_steer.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: result beat with nothing expected:",
                                 $realtime, " L=%0d R=%0d mask=%b err=%0d",
                                 got.duty_left, got.duty_right, got.line_mask,
                                 got.position_error);
                end else begin
                    want = pending_steer.pop_front();
                    if (got.duty_left !== want.duty_left || got.duty_right !== want.duty_right ||
                        got.line_mask !== want.line_mask ||
                        got.position_error !== want.position_error) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: steering mismatch: expected L=%0d R=%0d",
                                     $realtime, want.duty_left, want.duty_right,
                                     " mask=%b err=%0d,", want.line_mask,
                                     want.position_error,
                                     " got L=%0d R=%0d mask=%b err=%0d",
                                     got.duty_left, got.duty_right, got.line_mask,
                                     got.position_error);
                    end
                end
            end
            if (i_frame.valid && i_frame.ready) begin
                f[0] = i_frame.sample_0;
                f[1] = i_frame.sample_1;
                f[2] = i_frame.sample_2;
                f[3] = i_frame.sample_3;
                f[4] = i_frame.sample_4;
                f[5] = i_frame.sample_5;
                f[6] = i_frame.sample_6;
                pending_steer.push_back(predict_steering(f));
            end
        end
        o_pending = pending_steer.size();
    end

endmodule

@@ dv/line_sensor_pd_steering_tb.sv @@
// Top of the line sensor PD steering testbench: clock, reset, frame and register stimulus,
// result back-pressure and the final verdict.
// Depends on lsps_pkg, lsps_if, the block itself and line_sensor_pd_steering_checker.
module line_sensor_pd_steering_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [lsps_pkg::NUM_SENSORS-1:0][lsps_pkg::SAMPLE_BITS-1:0] t_frame;
    typedef logic [lsps_pkg::SAMPLE_BITS-1:0]                            t_sample;
    typedef logic [lsps_pkg::CFG_IDX_BITS-1:0]                           t_cfg_idx;
    typedef logic [lsps_pkg::CFG_DATA_BITS-1:0]                          t_cfg_data;

    localparam int SAMPLE_MAX  = (1 << lsps_pkg::SAMPLE_BITS) - 1;
    localparam int HOLD_CYCLES = 80;

    logic i_clk;
    logic i_rst_n;

    lsps_frame_if  frame_ch ();
    lsps_result_if result_ch ();
    lsps_cfg_if    cfg_ch ();

    int      fail_count;
    int      pending;
    t_sample cur_thr;
    bit      src_steady  = 1'b0;
    bit      sink_steady = 1'b0;
    int      hold_seq    = 0;

    line_sensor_pd_steering dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frame_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    line_sensor_pd_steering_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_frame      (frame_ch),
        .i_result     (result_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("[line_sensor_pd_steering] ERROR");
        $finish;
    end

    // The receiver stalls at random, except in steady stretches and one long hold-off.
    initial begin
        int seen;
        seen = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seq != seen) begin
                seen = hold_seq;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                result_ch.ready <= sink_steady || ($urandom_range(99) >= 18);
            end
        end
    end

    function automatic t_frame lone_frame(input int k, input t_sample rest,
                                          input t_sample hit);
        t_frame f;
        for (int j = 0; j < lsps_pkg::NUM_SENSORS; j++) f[j] = rest;
        f[k] = hit;
        return f;
    endfunction

    function automatic t_frame make_frame(input int hit_pct);
        t_frame f;
        for (int k = 0; k < lsps_pkg::NUM_SENSORS; k++) begin
            if ($urandom_range(99) < 8)
                f[k] = t_sample'($urandom);
            else if ($urandom_range(99) < hit_pct && cur_thr != SAMPLE_MAX)
                f[k] = t_sample'($urandom_range(SAMPLE_MAX, int'(cur_thr) + 1));
            else
                f[k] = t_sample'($urandom_range(int'(cur_thr), 0));
        end
        return f;
    endfunction

    task automatic send_frame(input t_frame f);
        if (!src_steady && $urandom_range(99) < 18) begin
            frame_ch.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        frame_ch.valid    <= 1'b1;
        frame_ch.sample_0 <= f[0];
        frame_ch.sample_1 <= f[1];
        frame_ch.sample_2 <= f[2];
        frame_ch.sample_3 <= f[3];
        frame_ch.sample_4 <= f[4];
        frame_ch.sample_5 <= f[5];
        frame_ch.sample_6 <= f[6];
        do @(posedge i_clk); while (!frame_ch.ready);
    endtask

    task automatic run_random(input int n);
        repeat (n) send_frame(make_frame($urandom_range(45, 0)));
    endtask

    task automatic drain();
        frame_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic reg_write(input t_cfg_idx idx, input t_cfg_data val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic apply_setting(input t_cfg_data thr, gp, gd, base, lim);
        drain();
        reg_write(lsps_pkg::REG_THRESHOLD, thr);
        reg_write(lsps_pkg::REG_GAIN_PROP, gp);
        reg_write(lsps_pkg::REG_GAIN_DERIV, gd);
        reg_write(lsps_pkg::REG_BASE_DUTY, base);
        reg_write(lsps_pkg::REG_DUTY_LIMIT, lim);
        cfg_ch.valid <= 1'b0;
        cur_thr = thr[lsps_pkg::SAMPLE_BITS-1:0];
    endtask

    initial begin
        t_frame f;
        frame_ch.valid    = 1'b0;
        frame_ch.sample_0 = '0;
        frame_ch.sample_1 = '0;
        frame_ch.sample_2 = '0;
        frame_ch.sample_3 = '0;
        frame_ch.sample_4 = '0;
        frame_ch.sample_5 = '0;
        frame_ch.sample_6 = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = lsps_pkg::REG_THRESHOLD;
        cfg_ch.data       = '0;
        i_rst_n           = 1'b0;
        cur_thr           = lsps_pkg::RST_THRESHOLD;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: no line, every sensor alone, threshold edges and multiple hits.
        send_frame('0);
        send_frame('1);
        for (int k = 0; k < lsps_pkg::NUM_SENSORS; k++) send_frame(lone_frame(k, '0, '1));
        send_frame('0);
        send_frame(lone_frame(0, cur_thr, cur_thr));
        send_frame(lone_frame(3, cur_thr, t_sample'(cur_thr + 1)));
        f = lone_frame(2, '0, '1);
        f[5] = '1;
        send_frame(f);
        send_frame(lone_frame(6, '0, '1));
        send_frame(lone_frame(0, '0, '1));
        run_random(50);
        hold_seq <= hold_seq + 1;
        run_random(100);

        // Writes to unused indices must leave the settings untouched.
        drain();
        for (int r = int'(lsps_pkg::REG_DUTY_LIMIT) + 1; r < (1 << lsps_pkg::CFG_IDX_BITS); r++)
            reg_write(t_cfg_idx'(r), t_cfg_data'($urandom));
        cfg_ch.valid <= 1'b0;
        run_random(40);

        // Upper extremes of gains and duties with a zero threshold, with neither side idling.
        apply_setting('0, '1, '1, '1, '1);
        src_steady = 1'b1;
        sink_steady <= 1'b1;
        run_random(150);
        src_steady = 1'b0;
        sink_steady <= 1'b0;

        // Lower extremes: nothing can exceed the threshold.
        apply_setting('1, '0, '0, '0, '0);
        run_random(60);

        // Base duty above the duty limit.
        apply_setting(12'd2000, 12'd50, 12'd30, 12'd3000, 12'd500);
        send_frame(lone_frame(6, '0, '1));
        send_frame('0);
        send_frame(lone_frame(0, '0, '1));
        send_frame(lone_frame(3, '0, '1));
        run_random(150);

        repeat (4) begin
            apply_setting(t_cfg_data'($urandom_range(4094, 1000)), t_cfg_data'($urandom),
                          t_cfg_data'($urandom), t_cfg_data'($urandom),
                          t_cfg_data'($urandom));
            run_random(120);
        end

        drain();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("[line_sensor_pd_steering] OK");
        else
            $display("[line_sensor_pd_steering] ERROR");
        $finish;
    end

endmodule

@@ line_sensor_pd_steering.f @@
rtl/lsps_pkg.sv
rtl/lsps_if.sv
rtl/lsps_steer_calc.sv
rtl/line_sensor_pd_steering.sv
rtl/lsps_checker.sv
dv/line_sensor_pd_steering_checker.sv
dv/line_sensor_pd_steering_tb.sv
